### rtl/qenc_pkg.sv
// qenc_pkg: shared types, codes and constants of the quadrature encoder unit
// holds the input and result word layouts, config register layout and the gray step table
// no dependencies
package qenc_pkg;

	// operation codes carried in each input word
	typedef enum logic [1:0] {
		OP_SAMPLE     = 2'd0,
		OP_TAKE_STEPS = 2'd1,
		OP_TAKE_CLICK = 2'd2,
		OP_TAKE_HOLD  = 2'd3
	} op_t;

	// configuration register indexes
	typedef enum logic [1:0] {
		REG_DEBOUNCE  = 2'd0,
		REG_CLICK_MIN = 2'd1,
		REG_HOLD      = 2'd2
	} reg_idx_t;

	// press tracking phases
	typedef enum logic [1:0] {
		PRESS_IDLE    = 2'd0,
		PRESS_PRESSED = 2'd1,
		PRESS_HELD    = 2'd2
	} press_t;

	// one quadrature transition
	typedef enum logic [1:0] {
		STEP_NONE = 2'd0,
		STEP_UP   = 2'd1,
		STEP_DOWN = 2'd2
	} step_t;

	localparam logic [3:0]  DEBOUNCE_RESET  = 4'd3;
	localparam logic [15:0] CLICK_MIN_RESET = 16'd5;
	localparam logic [15:0] HOLD_RESET      = 16'd160;
	localparam logic [15:0] ELAPSED_MAX     = 16'hffff;

	typedef struct packed {
		op_t  op;
		logic phase_a;
		logic phase_b;
		logic switch_level;
	} in_item_t;

	typedef struct packed {
		logic signed [29:0] steps;
		logic               click;
		logic               hold;
		logic signed [31:0] net_steps;
		logic [31:0]        skipped;
		logic               switch_stable;
	} out_item_t;

	typedef struct packed {
		logic [3:0]  debounce_count;
		logic [15:0] click_min_ticks;
		logic [15:0] hold_ticks;
	} cfg_regs_t;

	// button state seen by the encoder side
	typedef struct packed {
		logic stable;       // debounced level before this word
		logic stable_next;  // debounced level after this word
		logic click;        // click flag before this word
		logic hold;         // hold flag before this word
	} btn_status_t;

	// x4 gray decode, index is {previous A, previous B, A, B}
	function automatic step_t gray_step(input logic [3:0] idx);
		step_t s;
		unique case (idx)
			4'd1, 4'd7, 4'd8, 4'd14: s = STEP_DOWN;
			4'd2, 4'd4, 4'd11, 4'd13: s = STEP_UP;
			default: s = STEP_NONE;
		endcase
		return s;
	endfunction

endpackage

### rtl/qenc_button.sv
// qenc_button: switch debouncer with press timer, click and hold flags
// updated once per processed word by the top level
// depends on qenc_pkg
module qenc_button (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               tick,
	input  logic               take_click,
	input  logic               take_hold,
	input  logic               switch_level,
	input  qenc_pkg::cfg_regs_t cfg,
	output qenc_pkg::btn_status_t status
);
	import qenc_pkg::*;

	logic        cand_q, cand_n;
	logic [3:0]  run_q, run_n;
	logic        deb_q, deb_n;
	press_t      phase_q, phase_n;
	logic [15:0] elapsed_q, elapsed_n;
	logic        click_q, click_n;
	logic        hold_q, hold_n;

	always_comb begin
		cand_n    = cand_q;
		run_n     = run_q;
		deb_n     = deb_q;
		phase_n   = phase_q;
		elapsed_n = elapsed_q;
		click_n   = click_q;
		hold_n    = hold_q;
		if (tick) begin
			if (phase_q != PRESS_IDLE && elapsed_q != ELAPSED_MAX) begin
				elapsed_n = elapsed_q + 16'd1;
			end
			if (switch_level == cand_q) begin
				if (run_q < cfg.debounce_count) begin
					run_n = run_q + 4'd1;
				end
			end else begin
				cand_n = switch_level;
				run_n  = 4'd1;
			end
			if (run_n >= cfg.debounce_count && cand_n != deb_q) begin
				deb_n = cand_n;
				if (!cand_n) begin
					phase_n   = PRESS_PRESSED;
					elapsed_n = '0;
				end else begin
					if (phase_q == PRESS_PRESSED && elapsed_n >= cfg.click_min_ticks) begin
						click_n = 1'b1;
					end
					phase_n = PRESS_IDLE;
				end
			end
			// long press: raise hold and drop any pending click for this press
			if (!deb_n && phase_n == PRESS_PRESSED && elapsed_n >= cfg.hold_ticks) begin
				hold_n  = 1'b1;
				phase_n = PRESS_HELD;
			end
		end
		if (take_click) begin
			click_n = 1'b0;
		end
		if (take_hold) begin
			hold_n = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cand_q    <= 1'b1;
			run_q     <= DEBOUNCE_RESET;
			deb_q     <= 1'b1;
			phase_q   <= PRESS_IDLE;
			elapsed_q <= '0;
			click_q   <= 1'b0;
			hold_q    <= 1'b0;
		end else begin
			cand_q    <= cand_n;
			run_q     <= run_n;
			deb_q     <= deb_n;
			phase_q   <= phase_n;
			elapsed_q <= elapsed_n;
			click_q   <= click_n;
			hold_q    <= hold_n;
		end
	end

	assign status.stable      = deb_q;
	assign status.stable_next = deb_n;
	assign status.click       = click_q;
	assign status.hold        = hold_q;

endmodule

### rtl/quadrature_encoder_with_button_unit.sv
// quadrature_encoder_with_button_unit: x4 quadrature decoder with debounced push switch
// top level, instantiates qenc_button; depends on qenc_pkg
//
//  channel | handshake              | payload
//  --------+------------------------+--------------------------------------
//  in      | in_valid / in_ready    | in_data   (op, phase_a, phase_b, switch_level)
//  out     | out_valid / out_ready  | out_data  (steps, click, hold, net_steps, ...)
//  cfg     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// one word per clock sustained while out_ready stays high; an accepted word passes the input
// register, then all state updates and the result register in one pass
// a stalled result register holds the input register; in_ready falls only when both are full
// asynchronous reset restores idle pulled-up levels and the register defaults; cfg_ready is
// always high
module quadrature_encoder_with_button_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  qenc_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output qenc_pkg::out_item_t out_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [1:0]          cfg_index,
	input  logic [15:0]         cfg_data
);
	import qenc_pkg::*;

	logic        valid_s1;
	in_item_t    item_s1;
	logic        valid_s2;
	out_item_t   result_s2;
	logic        advance;
	logic        process;

	cfg_regs_t   cfg_q;
	logic [1:0]  last_q, last_n;
	logic [31:0] pending_q, pending_n;
	logic [31:0] net_q, net_n;
	logic [31:0] skip_q, skip_n;

	btn_status_t status;
	step_t       step;
	logic [1:0]  level;
	logic [31:0] biased;
	logic [31:0] quot;
	logic [29:0] steps_v;

	assign advance   = !valid_s2 || out_ready;
	assign process   = valid_s1 && advance;
	assign in_ready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_count  <= DEBOUNCE_RESET;
			cfg_q.click_min_ticks <= CLICK_MIN_RESET;
			cfg_q.hold_ticks      <= HOLD_RESET;
		end else if (cfg_valid) begin
			unique case (reg_idx_t'(cfg_index))
				REG_DEBOUNCE:  cfg_q.debounce_count  <= cfg_data[3:0];
				REG_CLICK_MIN: cfg_q.click_min_ticks <= cfg_data;
				REG_HOLD:      cfg_q.hold_ticks      <= cfg_data;
				default: ;
			endcase
		end
	end

	qenc_button u_button (
		.clk          (clk),
		.arst_n       (arst_n),
		.tick         (process && item_s1.op == OP_SAMPLE),
		.take_click   (process && item_s1.op == OP_TAKE_CLICK),
		.take_hold    (process && item_s1.op == OP_TAKE_HOLD),
		.switch_level (item_s1.switch_level),
		.cfg          (cfg_q),
		.status       (status)
	);

	assign level = {item_s1.phase_a, item_s1.phase_b};
	assign step  = gray_step({last_q, level});

	// divide by four rounding toward zero: bias negatives by three, then shift
	assign biased = pending_q + {30'd0, {2{pending_q[31]}}};
	assign quot   = {{2{biased[31]}}, biased[31:2]};

	always_comb begin
		last_n    = last_q;
		pending_n = pending_q;
		net_n     = net_q;
		skip_n    = skip_q;
		steps_v   = '0;
		unique case (item_s1.op)
			OP_SAMPLE: begin
				last_n = level;
				if (step == STEP_UP) begin
					pending_n = pending_q + 32'd1;
				end else if (step == STEP_DOWN) begin
					pending_n = pending_q - 32'd1;
				end else if (last_q != level) begin
					skip_n = skip_q + 32'd1;
				end
			end
			OP_TAKE_STEPS: begin
				if (!status.stable) begin
					// taken while pressed: edges are thrown away
					pending_n = '0;
				end else begin
					pending_n = pending_q - {quot[29:0], 2'b00};
					net_n     = net_q + quot;
					steps_v   = quot[29:0];
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q    <= 2'b11;
			pending_q <= '0;
			net_q     <= '0;
			skip_q    <= '0;
		end else if (process) begin
			last_q    <= last_n;
			pending_q <= pending_n;
			net_q     <= net_n;
			skip_q    <= skip_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
		end
		if (process) begin
			result_s2.steps         <= steps_v;
			result_s2.click         <= (item_s1.op == OP_TAKE_CLICK) && status.click;
			result_s2.hold          <= (item_s1.op == OP_TAKE_HOLD) && status.hold;
			result_s2.net_steps     <= net_n;
			result_s2.skipped       <= skip_n;
			result_s2.switch_stable <= status.stable_next;
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = result_s2;

endmodule

### rtl/qenc_checker.sv
// qenc_checker: port-level assertions for the quadrature encoder unit
// bound to quadrature_encoder_with_button_unit; depends on qenc_pkg
module qenc_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input qenc_pkg::out_item_t out_data
);
	import qenc_pkg::*;

	// a stalled result word stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result word changed while stalled");

	// with no result waiting the unit always takes a word
	a_in_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output");

	// each word takes at most one of steps, click or hold
	a_one_take: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.steps == '0 && !(out_data.click && out_data.hold))
			|| (!out_data.click && !out_data.hold))
		else $error("more than one take in one result word");

	// no detents come out while the switch is down
	a_no_steps_pressed: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.switch_stable |-> out_data.steps == '0)
		else $error("detents reported while pressed");

endmodule

bind quadrature_encoder_with_button_unit qenc_checker u_qenc_checker (.*);
